FILE: rtl/core/svc_pkg.sv
// Shared types and constants for the score voting classifier.
// Used by svc_vote_unit and score_voting_classifier.
// No dependencies.
package svc_pkg;

  // Fixed field widths
  localparam int unsigned CH_W    = 3;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned LABEL_W = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned REPS_W  = 5;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Score of a target label: 1.0 in Q16.16
  localparam logic [SCORE_W-1:0] ONE_Q16 = 32'h0001_0000;
  // Most negative score and its saturated negation
  localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPETITIONS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONTARGET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_BASE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_FIRST   = 3'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_CHECK,
    S_DEC_LOAD,
    S_DEC_READ,
    S_DRAIN,
    S_FINISH
  } svc_state_t;

  // One score read travelling from the sequencer to the vote unit
  typedef struct packed {
    logic valid;
    logic first_rep;
    logic last_rep;
    logic first_ch;
    logic last_ch;
  } svc_beat_t;

endpackage

FILE: rtl/core/svc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the per-channel score and time queues; no dependencies.
module svc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/svc_vote_unit.sv
// Shared accumulator and compare unit: sums one channel's scores a beat
// at a time, then compares the sum against the running best. Uses svc_pkg.
module svc_vote_unit #(
  parameter int unsigned CHANNELS   = 8,
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  svc_pkg::svc_beat_t            beat,
  input  logic [$clog2(CHANNELS)-1:0]   beat_ch,
  input  logic [svc_pkg::SCORE_W-1:0]   rd_score,
  input  logic [svc_pkg::TIME_W-1:0]    rd_time,
  input  logic [svc_pkg::LABEL_W-1:0]   result_base,
  input  logic [svc_pkg::LABEL_W-1:0]   reject_label,
  input  logic                          keep_first,
  output logic                          done,
  output logic [svc_pkg::LABEL_W-1:0]   win_label,
  output logic [svc_pkg::TIME_W-1:0]    win_time
);

  localparam int unsigned SUM_W = svc_pkg::SCORE_W + $clog2(FIFO_DEPTH) + 1;
  localparam int unsigned CW    = $clog2(CHANNELS);

  logic signed [SUM_W-1:0] score_ext;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic signed [SUM_W-1:0] best_r;
  logic [svc_pkg::TIME_W-1:0]  time_r;
  logic [CW-1:0]               cmp_ch_r;
  logic                        cmp_v_r, cmp_first_r, cmp_last_r;
  logic                        done_r;
  logic [svc_pkg::LABEL_W-1:0] label_r;
  logic [svc_pkg::TIME_W-1:0]  when_r;

  // Sign-extend the score and add it into the running sum
  assign score_ext = {{(SUM_W-svc_pkg::SCORE_W){rd_score[svc_pkg::SCORE_W-1]}}, rd_score};
  assign acc_nxt   = beat.first_rep ? score_ext : acc_r + score_ext;

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= beat.valid && beat.last_rep;
    end
    if (beat.valid) begin
      acc_r <= acc_nxt;
    end
    if (beat.valid && beat.last_rep) begin
      time_r      <= rd_time;
      cmp_ch_r    <= beat_ch;
      cmp_first_r <= beat.first_ch;
      cmp_last_r  <= beat.last_ch;
    end
  end

  // Compare stage: strict maximum wins, a tie rejects unless keep-first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= cmp_v_r && cmp_last_r;
    end
    if (cmp_v_r) begin
      if (cmp_first_r || (acc_r > best_r)) begin
        best_r  <= acc_r;
        label_r <= result_base + svc_pkg::LABEL_W'(cmp_ch_r);
        when_r  <= time_r;
      end else if ((acc_r == best_r) && !keep_first) begin
        label_r <= reject_label;
        when_r  <= time_r;
      end
    end
  end

  assign done      = done_r;
  assign win_label = label_r;
  assign win_time  = when_r;

`ifndef SYNTHESIS
  // A decision completes only right after the last channel was compared
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cmp_v_r) && $past(cmp_last_r))
    else $error("vote done without a final compare");
`endif

endmodule

FILE: rtl/core/score_voting_classifier.sv
// Top level of the score voting classifier: configuration registers,
// per-channel queue control, sequencer and output register.
// Uses svc_pkg, svc_ram and svc_vote_unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one classifier event per beat:
//   channel, label, Q16.16 value and 32.32 timestamp. The event is scored and
//   pushed into its channel's queue; a full queue drops it and sets a sticky
//   overflow flag. Output channel (out_valid/out_ready) carries one decision
//   beat whenever every channel holds at least N scores.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index at once;
//   write only while the block is idle.
//   Timing: an event that triggers no decision passes the push and check
//   states before in_ready returns. A decision reads the queues through one
//   RAM read port, one score per cycle, with a load state before each channel;
//   the output beat is loaded once the vote unit is done.
//   in_ready is low while an event or decision is in progress.
//   If the receiver stalls, the decision waits in the output register; the
//   block accepts further events meanwhile and stalls only when the next
//   decision needs the output register.
//   Reset (rst_n low, synchronous) empties all queues, clears the overflow
//   flag and the output valid flag, and restores register defaults.
module score_voting_classifier #(
  parameter int unsigned CHANNELS   = 8,
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port
  input  logic                          cfg_we,
  input  logic [svc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [svc_pkg::CFG_W-1:0]     cfg_wdata,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [svc_pkg::CH_W-1:0]      in_channel,
  input  logic [svc_pkg::LABEL_W-1:0]   in_event_label,
  input  logic signed [svc_pkg::SCORE_W-1:0] in_event_value,
  input  logic [svc_pkg::TIME_W-1:0]    in_event_time,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [svc_pkg::LABEL_W-1:0]   out_chosen_label,
  output logic [svc_pkg::TIME_W-1:0]    out_chosen_time,
  output logic                          out_rejected,
  output logic                          out_overflow_seen
);

  localparam int unsigned CW     = $clog2(CHANNELS);
  localparam int unsigned DEPTH  = CHANNELS * FIFO_DEPTH;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);

  // Configuration registers
  logic                          value_mode_r;
  logic [svc_pkg::REPS_W-1:0]    reps_r;
  logic [svc_pkg::LABEL_W-1:0]   target_r, nontarget_r, reject_r, base_label_r;
  logic                          keep_first_r;

  // Sequencer and queue state
  svc_pkg::svc_state_t state_r, state_nxt;
  logic [CNT_W-1:0]            fill_r [CHANNELS];
  logic [PTR_W-1:0]            rp_r   [CHANNELS];
  logic                        ovf_r;

  // Captured event
  logic [CW-1:0]               in_idx_r;
  logic                        push_en_r;
  logic [svc_pkg::SCORE_W-1:0] in_score_r;
  logic [svc_pkg::TIME_W-1:0]  in_time_r;

  // Decision walk
  logic [CW-1:0]               dec_ch_r;
  logic [AW-1:0]               base_r;
  logic [PTR_W-1:0]            ptr_r;
  logic [CNT_W-1:0]            rep_r;
  svc_pkg::svc_beat_t          beat_r;
  logic [CW-1:0]               beat_ch_r;

  // Output register
  logic                        out_valid_r;
  logic [svc_pkg::LABEL_W-1:0] out_label_r;
  logic [svc_pkg::TIME_W-1:0]  out_time_r;
  logic                        out_rej_r, out_ovf_r;

  // Control
  logic                        accept, push_do, push_full, dec_issue, last_rep, last_ch;
  logic                        load_out, all_full, start_dec;
  logic [CNT_W-1:0]            n_eff;
  logic [CW-1:0]               sel_ch;
  logic [CNT_W-1:0]            fill_sel;
  logic [PTR_W-1:0]            ptr_inc;
  logic [CNT_W:0]              wpos_sum;
  logic [PTR_W-1:0]            wpos;
  logic [AW-1:0]               waddr, raddr;
  logic [31:0]                 ch_ext;
  logic                        ch_ok;
  logic                        score_ok;
  logic [svc_pkg::SCORE_W-1:0] score_nxt;
  logic [svc_pkg::SCORE_W-1:0] rd_score;
  logic [svc_pkg::TIME_W-1:0]  rd_time;
  logic                        vote_done;
  logic [svc_pkg::LABEL_W-1:0] win_label;
  logic [svc_pkg::TIME_W-1:0]  win_time;
  logic [31:0]                 n_wide;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_mode_r <= 1'b0;
      reps_r       <= svc_pkg::REPS_W'(1);
      target_r     <= svc_pkg::LABEL_W'(1);
      nontarget_r  <= svc_pkg::LABEL_W'(2);
      reject_r     <= '0;
      base_label_r <= svc_pkg::LABEL_W'(16);
      keep_first_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        svc_pkg::REG_VALUE_MODE:  value_mode_r <= cfg_wdata[0];
        svc_pkg::REG_REPETITIONS: reps_r       <= cfg_wdata[svc_pkg::REPS_W-1:0];
        svc_pkg::REG_TARGET:      target_r     <= cfg_wdata;
        svc_pkg::REG_NONTARGET:   nontarget_r  <= cfg_wdata;
        svc_pkg::REG_REJECT:      reject_r     <= cfg_wdata;
        svc_pkg::REG_RESULT_BASE: base_label_r <= cfg_wdata;
        svc_pkg::REG_KEEP_FIRST:  keep_first_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective repetition count: zero counts as one, saturate at the depth
  assign n_wide = (reps_r == '0) ? 32'd1 :
                  ((32'(reps_r) > FIFO_DEPTH) ? 32'(FIFO_DEPTH) : 32'(reps_r));
  assign n_eff  = n_wide[CNT_W-1:0];

  // Score the incoming event
  assign ch_ext = 32'(in_channel);
  assign ch_ok  = ch_ext < CHANNELS;
  always_comb begin
    score_ok  = 1'b1;
    score_nxt = '0;
    if (value_mode_r) begin
      if (in_event_value == svc_pkg::SCORE_MIN) begin
        score_nxt = svc_pkg::SCORE_MAX;
      end else begin
        score_nxt = ~in_event_value + svc_pkg::SCORE_W'(1);
      end
    end else if (in_event_label == target_r) begin
      score_nxt = svc_pkg::ONE_Q16;
    end else if ((in_event_label == nontarget_r) || (in_event_label == reject_r)) begin
      score_nxt = '0;
    end else begin
      score_ok = 1'b0;
    end
  end

  // Per-channel queue status, one channel selected at a time
  assign sel_ch    = (state_r == svc_pkg::S_PUSH) ? in_idx_r : dec_ch_r;
  assign fill_sel  = fill_r[sel_ch];
  assign push_full = fill_sel >= CNT_W'(FIFO_DEPTH);
  assign wpos_sum  = (CNT_W+1)'(rp_r[sel_ch]) + (CNT_W+1)'(fill_sel);
  assign wpos      = (wpos_sum >= (CNT_W+1)'(FIFO_DEPTH)) ?
                     PTR_W'(wpos_sum - (CNT_W+1)'(FIFO_DEPTH)) : PTR_W'(wpos_sum);
  assign waddr     = AW'(in_idx_r) * AW'(FIFO_DEPTH) + AW'(wpos);
  assign ptr_inc   = (ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr_r + PTR_W'(1);
  assign raddr     = base_r + AW'(ptr_r);
  assign last_rep  = rep_r == (n_eff - CNT_W'(1));
  assign last_ch   = dec_ch_r == CW'(CHANNELS - 1);

  // Every channel holds a full batch
  always_comb begin
    all_full = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (fill_r[i] < n_eff) begin
        all_full = 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svc_pkg::S_IDLE:     if (in_valid) state_nxt = svc_pkg::S_PUSH;
      svc_pkg::S_PUSH:     state_nxt = svc_pkg::S_CHECK;
      svc_pkg::S_CHECK:    state_nxt = all_full ? svc_pkg::S_DEC_LOAD : svc_pkg::S_IDLE;
      svc_pkg::S_DEC_LOAD: state_nxt = svc_pkg::S_DEC_READ;
      svc_pkg::S_DEC_READ: begin
        if (last_rep) begin
          state_nxt = last_ch ? svc_pkg::S_DRAIN : svc_pkg::S_DEC_LOAD;
        end
      end
      svc_pkg::S_DRAIN:    if (vote_done) state_nxt = svc_pkg::S_FINISH;
      svc_pkg::S_FINISH:   if (!out_valid_r || out_ready) state_nxt = svc_pkg::S_IDLE;
      default:             state_nxt = svc_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    push_do   = 1'b0;
    start_dec = 1'b0;
    dec_issue = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      svc_pkg::S_IDLE:     in_ready  = 1'b1;
      svc_pkg::S_PUSH:     push_do   = push_en_r;
      svc_pkg::S_CHECK:    start_dec = all_full;
      svc_pkg::S_DEC_READ: dec_issue = 1'b1;
      svc_pkg::S_FINISH:   load_out  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Sequencer, queue bookkeeping and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= svc_pkg::S_IDLE;
      ovf_r        <= 1'b0;
      beat_r       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        fill_r[i] <= '0;
        rp_r[i]   <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      beat_r.valid <= dec_issue;
      // Drop on a full queue, otherwise count the new entry
      if (push_do) begin
        if (push_full) begin
          ovf_r <= 1'b1;
        end else begin
          fill_r[sel_ch] <= fill_sel + CNT_W'(1);
        end
      end
      // Pop a batch from the channel just read
      if (dec_issue && last_rep) begin
        fill_r[sel_ch] <= fill_sel - n_eff;
        rp_r[sel_ch]   <= ptr_inc;
      end
      if (load_out) begin
        ovf_r <= 1'b0;
      end
    end
    beat_r.first_rep <= rep_r == '0;
    beat_r.last_rep  <= last_rep;
    beat_r.first_ch  <= dec_ch_r == '0;
    beat_r.last_ch   <= last_ch;
    beat_ch_r        <= dec_ch_r;
  end

  // Capture the event, walk the channels during a decision
  always_ff @(posedge clk) begin
    if (accept) begin
      in_idx_r   <= ch_ext[CW-1:0];
      push_en_r  <= ch_ok && score_ok;
      in_score_r <= score_nxt;
      in_time_r  <= in_event_time;
    end
    if (start_dec) begin
      dec_ch_r <= '0;
      base_r   <= '0;
    end
    if (state_r == svc_pkg::S_DEC_LOAD) begin
      ptr_r <= rp_r[sel_ch];
      rep_r <= '0;
    end
    if (dec_issue) begin
      ptr_r <= ptr_inc;
      rep_r <= rep_r + CNT_W'(1);
      if (last_rep) begin
        dec_ch_r <= dec_ch_r + CW'(1);
        base_r   <= base_r + AW'(FIFO_DEPTH);
      end
    end
  end

  // Queue storage
  svc_ram #(.WIDTH(svc_pkg::SCORE_W), .DEPTH(DEPTH)) u_score_ram (
    .clk   (clk),
    .we    (push_do && !push_full),
    .waddr (waddr),
    .wdata (in_score_r),
    .raddr (raddr),
    .rdata (rd_score)
  );

  svc_ram #(.WIDTH(svc_pkg::TIME_W), .DEPTH(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (push_do && !push_full),
    .waddr (waddr),
    .wdata (in_time_r),
    .raddr (raddr),
    .rdata (rd_time)
  );

  // Shared sum and compare unit
  svc_vote_unit #(.CHANNELS(CHANNELS), .FIFO_DEPTH(FIFO_DEPTH)) u_vote (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (beat_r),
    .beat_ch      (beat_ch_r),
    .rd_score     (rd_score),
    .rd_time      (rd_time),
    .result_base  (base_label_r),
    .reject_label (reject_r),
    .keep_first   (keep_first_r),
    .done         (vote_done),
    .win_label    (win_label),
    .win_time     (win_time)
  );

  // Output register: hold the decision until the receiver takes the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_label_r <= win_label;
      out_time_r  <= win_time;
      out_rej_r   <= win_label == reject_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chosen_label  = out_label_r;
  assign out_chosen_time   = out_time_r;
  assign out_rejected      = out_rej_r;
  assign out_overflow_seen = out_ovf_r;

`ifndef SYNTHESIS
  // A queue never counts more entries than it holds
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_sel <= CNT_W'(FIFO_DEPTH))
    else $error("queue fill count above depth");

  // The vote unit finishes only while the sequencer waits for it
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    vote_done |-> state_r == svc_pkg::S_DRAIN)
    else $error("vote done outside drain");

  // A full batch on every channel starts a decision
  a_start_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svc_pkg::S_CHECK) && all_full |=> state_r == svc_pkg::S_DEC_LOAD)
    else $error("decision not started");

  // Loading a decision clears the overflow flag
  a_ovf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> !ovf_r && out_valid_r)
    else $error("overflow flag not cleared on decision");
`endif

endmodule
